// File: hdl/skt_pkg.sv
// ----------------------------------------------------------------------------
// skt_pkg
// Shared types and constants for the sorted key table.
// ----------------------------------------------------------------------------
package skt_pkg;

    localparam int ENTRIES      = 256;
    localparam int KEY_BITS     = 32;
    localparam int PAYLOAD_BITS = 32;
    localparam int ADDR_BITS    = $clog2(ENTRIES);
    localparam int CNT_BITS     = $clog2(ENTRIES + 1);
    localparam int ENTRY_BITS   = KEY_BITS + PAYLOAD_BITS;

    localparam int FUNC_W  = 2;
    localparam int KEY_W   = 32;
    localparam int PAY_W   = 32;
    localparam int IDX_W   = 8;
    localparam int POS_W   = 8;
    localparam int TCNT_W  = 9;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_DELETE = 2'd1,
        FUNC_DEL_RANGE = 2'd2,
        FUNC_SEARCH = 2'd3
    } t_func;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UB_RD,
        ST_UB_CMP,
        ST_FIND_RD,
        ST_FIND_CMP,
        ST_SHUP_RD,
        ST_SHUP_WR,
        ST_INS_WR,
        ST_SHDN_RD,
        ST_SHDN_WR,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic                  ok;
        logic [POS_W-1:0]      position;
        logic [PAY_W-1:0]      match_payload;
        logic [TCNT_W-1:0]     table_count;
    } t_result;

    typedef struct packed {
        t_func             func;
        logic [KEY_W-1:0]  key;
        logic [PAY_W-1:0]  payload;
        logic [IDX_W-1:0]  first_index;
        logic [IDX_W-1:0]  last_index;
    } t_request;

    // memory port request from sequencer to entry memory
    typedef struct packed {
        logic                  rd_en;
        logic [ADDR_BITS-1:0]  rd_addr;
        logic                  wr_en;
        logic [ADDR_BITS-1:0]  wr_addr;
        logic [ENTRY_BITS-1:0] wr_data;
    } t_mem_req;

endpackage

// File: hdl/skt_stream_if.sv
// ----------------------------------------------------------------------------
// skt_stream_if
// Valid/ready channel carrying one item of type T.
// ----------------------------------------------------------------------------
interface skt_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/skt_entry_ram.sv
// ----------------------------------------------------------------------------
// skt_entry_ram
// Entry memory, one read and one write port, registered read data.
// ----------------------------------------------------------------------------
module skt_entry_ram
    import skt_pkg::*;
(
    input  logic                  i_clk,
    input  t_mem_req              i_req,
    output logic [ENTRY_BITS-1:0] o_rd_data
);

    logic [ENTRY_BITS-1:0] r_mem [ENTRIES];
    logic [ENTRY_BITS-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hdl/skt_ctrl.sv
// ----------------------------------------------------------------------------
// skt_ctrl
// Sequencer: binary search, shift up/down, result build.
// ----------------------------------------------------------------------------
module skt_ctrl
    import skt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_req_valid,
    output logic                  o_req_ready,
    input  t_request              i_req,
    output logic                  o_res_valid,
    input  logic                  i_res_ready,
    output t_result               o_res,
    output t_mem_req              o_mem,
    input  logic [ENTRY_BITS-1:0] i_rd_data
);

    t_state                r_state, n_state;
    t_request              r_req, n_req;
    logic [CNT_BITS-1:0]   r_count, n_count;
    // search bounds; signed-style hi via one extra bit
    logic [CNT_BITS:0]     r_lo, n_lo;
    logic [CNT_BITS:0]     r_hi, n_hi;
    logic [CNT_BITS-1:0]   r_ptr, n_ptr;   // shift pointer
    logic [CNT_BITS-1:0]   r_gap, n_gap;
    logic [CNT_BITS-1:0]   r_at, n_at;
    t_result               r_res, n_res;   // working result
    t_result               r_out, n_out;   // result held on the output channel
    logic                  r_res_valid, n_res_valid;

    logic [CNT_BITS:0]     w_mid;
    logic [KEY_BITS-1:0]   w_rkey;
    logic [PAYLOAD_BITS-1:0] w_rpay;
    logic [KEY_BITS-1:0]   w_key;
    logic [PAYLOAD_BITS-1:0] w_pay;
    logic                  w_accept;
    logic                  w_res_free;

    assign w_mid  = r_lo + ((r_hi - r_lo) >> 1);
    assign w_rkey = i_rd_data[ENTRY_BITS-1 -: KEY_BITS];
    assign w_rpay = i_rd_data[PAYLOAD_BITS-1:0];
    assign w_key  = KEY_BITS'(r_req.key);
    assign w_pay  = PAYLOAD_BITS'(r_req.payload);
    assign w_res_free = !r_res_valid || i_res_ready;
    assign w_accept = i_req_valid && o_req_ready;

    assign o_req_ready = (r_state == ST_IDLE);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_out;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    unique case (i_req.func)
                        FUNC_INSERT:    n_state = ST_UB_RD;
                        FUNC_SEARCH:    n_state = ST_FIND_RD;
                        FUNC_DELETE,
                        FUNC_DEL_RANGE: n_state = ST_SHDN_RD;
                        default:        n_state = ST_IDLE;
                    endcase
                end
            end
            ST_UB_RD: begin
                if (r_count == CNT_BITS'(ENTRIES)) n_state = ST_DONE;
                else if (r_lo >= r_hi) n_state = ST_SHUP_RD;
                else n_state = ST_UB_CMP;
            end
            ST_UB_CMP:   n_state = ST_UB_RD;
            ST_FIND_RD: begin
                if ($signed(r_lo) > $signed(r_hi)) n_state = ST_DONE;
                else n_state = ST_FIND_CMP;
            end
            ST_FIND_CMP: begin
                if (w_rkey == w_key) n_state = ST_DONE;
                else n_state = ST_FIND_RD;
            end
            ST_SHUP_RD: begin
                if (r_ptr > r_at) n_state = ST_SHUP_WR;
                else n_state = ST_INS_WR;
            end
            ST_SHUP_WR:  n_state = ST_SHUP_RD;
            ST_INS_WR:   n_state = ST_DONE;
            ST_SHDN_RD: begin
                if (r_ptr < r_count && r_gap != '0) n_state = ST_SHDN_WR;
                else n_state = ST_DONE;
            end
            ST_SHDN_WR:  n_state = ST_SHDN_RD;
            ST_DONE: begin
                if (w_res_free) n_state = ST_IDLE;
            end
            default:     n_state = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_req       = r_req;
        n_count     = r_count;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_ptr       = r_ptr;
        n_gap       = r_gap;
        n_at        = r_at;
        n_res       = r_res;
        n_out       = r_out;
        n_res_valid = r_res_valid && !i_res_ready;
        o_mem       = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_req = i_req;
                    n_res = '0;
                    n_lo  = '0;
                    n_gap = '0;
                    if (i_req.func == FUNC_SEARCH) begin
                        n_hi = {1'b0, r_count} - 1'b1;
                    end else begin
                        n_hi = {1'b0, r_count};
                    end
                    // delete validation
                    if (i_req.func == FUNC_DELETE &&
                        CNT_BITS'(i_req.first_index) < r_count) begin
                        n_gap = CNT_BITS'(1);
                        n_ptr = CNT_BITS'(i_req.first_index) + 1'b1;
                    end else if (i_req.func == FUNC_DEL_RANGE && r_count != '0 &&
                                 i_req.first_index <= i_req.last_index &&
                                 CNT_BITS'(i_req.last_index) < r_count) begin
                        n_gap = CNT_BITS'(i_req.last_index) -
                                CNT_BITS'(i_req.first_index) + 1'b1;
                        n_ptr = CNT_BITS'(i_req.last_index) + 1'b1;
                    end
                end
            end
            ST_UB_RD: begin
                o_mem.rd_en   = 1'b1;
                o_mem.rd_addr = ADDR_BITS'(w_mid);
                if (r_count != CNT_BITS'(ENTRIES) && r_lo >= r_hi) begin
                    n_at  = CNT_BITS'(r_lo);
                    n_ptr = r_count;
                end
            end
            ST_UB_CMP: begin
                if (w_rkey > w_key) n_hi = w_mid;
                else n_lo = w_mid + 1'b1;
            end
            ST_FIND_RD: begin
                o_mem.rd_en   = 1'b1;
                o_mem.rd_addr = ADDR_BITS'(w_mid);
            end
            ST_FIND_CMP: begin
                if (w_rkey > w_key) n_hi = w_mid - 1'b1;
                else if (w_rkey < w_key) n_lo = w_mid + 1'b1;
                else begin
                    n_res.ok            = 1'b1;
                    n_res.position      = POS_W'(w_mid);
                    n_res.match_payload = PAY_W'(w_rpay);
                end
            end
            ST_SHUP_RD: begin
                o_mem.rd_en   = 1'b1;
                o_mem.rd_addr = ADDR_BITS'(r_ptr - 1'b1);
            end
            ST_SHUP_WR: begin
                o_mem.wr_en   = 1'b1;
                o_mem.wr_addr = ADDR_BITS'(r_ptr);
                o_mem.wr_data = i_rd_data;
                n_ptr = r_ptr - 1'b1;
            end
            ST_INS_WR: begin
                o_mem.wr_en   = 1'b1;
                o_mem.wr_addr = ADDR_BITS'(r_at);
                o_mem.wr_data = {w_key, w_pay};
                n_count = r_count + 1'b1;
                n_res.ok       = 1'b1;
                n_res.position = POS_W'(r_at);
            end
            ST_SHDN_RD: begin
                o_mem.rd_en   = 1'b1;
                o_mem.rd_addr = ADDR_BITS'(r_ptr);
                if (!(r_ptr < r_count) && r_gap != '0) begin
                    n_count  = r_count - r_gap;
                    n_res.ok = 1'b1;
                end
            end
            ST_SHDN_WR: begin
                o_mem.wr_en   = 1'b1;
                o_mem.wr_addr = ADDR_BITS'(r_ptr - r_gap);
                o_mem.wr_data = i_rd_data;
                n_ptr = r_ptr + 1'b1;
            end
            ST_DONE: begin
                // hand the finished item to the output register
                if (w_res_free) begin
                    n_out             = r_res;
                    n_out.table_count = TCNT_W'(r_count);
                    n_res_valid       = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_res_valid <= n_res_valid;
        end
        r_req <= n_req;
        r_lo  <= n_lo;
        r_hi  <= n_hi;
        r_ptr <= n_ptr;
        r_gap <= n_gap;
        r_at  <= n_at;
        r_res <= n_res;
        r_out <= n_out;
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_BITS'(ENTRIES))
        else $error("entry count above capacity");
    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !o_mem.wr_en)
        else $error("memory write while idle");
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_INS_WR) |=> (r_count == $past(r_count) + 1'b1))
        else $error("insert did not bump count");
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && !i_res_ready) |=> $stable(r_out))
        else $error("pending result changed");
`endif

endmodule

// File: hdl/sorted_key_table.sv
// Insert runs an upper-bound binary search, shifts the entries above the slot up
//   and writes the new entry; search is a binary search; delete moves later entries down over the gap.
// Throughput: one item at a time; the shift loop goes through the entry memory
//   (one read and one write port), read then write per entry.
// Reset: synchronous active-low i_rst_n empties the table; memory is not cleared.
// ----------------------------------------------------------------------------
// sorted_key_table
// Sorted key/payload table with binary search insert and search, and delete by index or index range.
// ----------------------------------------------------------------------------
module sorted_key_table
    import skt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    skt_stream_if.sink           i_req,
    skt_stream_if.source         o_res
);

    t_mem_req              w_mem;
    logic [ENTRY_BITS-1:0] w_rd_data;
    t_result               w_res;

    // sequencer owns all control; memory holds the sorted entries
    skt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_req       (i_req.data),
        .o_res_valid (o_res.valid),
        .i_res_ready (o_res.ready),
        .o_res       (w_res),
        .o_mem       (w_mem),
        .i_rd_data   (w_rd_data)
    );

    skt_entry_ram u_ram (
        .i_clk     (i_clk),
        .i_req     (w_mem),
        .o_rd_data (w_rd_data)
    );

    assign o_res.data = w_res;

endmodule

// File: tb/sv/sorted_key_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_table_tb
// Drives inserts, deletes, range deletes and searches into the sorted key
// table and checks every result against a local model of the sorted table.
// ----------------------------------------------------------------------------
module sorted_key_table_tb;
    import skt_pkg::*;

    localparam int DIRECTED_ROWS = 20;
    localparam int RANDOM_ITEMS  = 890;
    localparam longint CYCLE_LIMIT = 4000000;

    logic i_clk;
    logic i_rst_n;

    skt_stream_if #(.T(t_request)) req_if ();
    skt_stream_if #(.T(t_result))  res_if ();

    sorted_key_table u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_res   (res_if.source)
    );

    always begin
        i_clk = 1'b0; #5;
        i_clk = 1'b1; #5;
    end

    // local copy of the table
    logic [KEY_W-1:0]  model_keys [ENTRIES];
    logic [PAY_W-1:0]  model_pays [ENTRIES];
    int                model_count;

    t_result result_queue [$];
    int      err_count;
    longint  cycle_count;
    logic    hold_off;     // long receiver stall window
    int      sent_items;

    // Apply one request to the local table and return its result.
    function automatic t_result apply_request(t_request rq);
        t_result r;
        int lo, hi, mid, gap;
        r = '0;
        case (rq.func)
            FUNC_INSERT: begin
                if (model_count < ENTRIES) begin
                    // upper bound: after all equal keys
                    lo = 0; hi = model_count;
                    while (lo < hi) begin
                        mid = lo + (hi - lo) / 2;
                        if (model_keys[mid] > rq.key) hi = mid;
                        else lo = mid + 1;
                    end
                    for (int i = model_count; i > lo; i--) begin
                        model_keys[i] = model_keys[i-1];
                        model_pays[i] = model_pays[i-1];
                    end
                    model_keys[lo] = rq.key;
                    model_pays[lo] = rq.payload;
                    model_count++;
                    r.ok = 1'b1;
                    r.position = lo[POS_W-1:0];
                end
            end
            FUNC_DELETE, FUNC_DEL_RANGE: begin
                lo = int'(rq.first_index);
                hi = (rq.func == FUNC_DELETE) ? lo : int'(rq.last_index);
                if (model_count != 0 && lo <= hi && hi < model_count) begin
                    gap = hi - lo + 1;
                    for (int i = hi + 1; i < model_count; i++) begin
                        model_keys[i-gap] = model_keys[i];
                        model_pays[i-gap] = model_pays[i];
                    end
                    model_count -= gap;
                    r.ok = 1'b1;
                end
            end
            default: begin
                // midpoint search, first equal hit wins
                lo = 0; hi = model_count - 1;
                while (lo <= hi) begin
                    mid = lo + (hi - lo) / 2;
                    if (model_keys[mid] > rq.key) hi = mid - 1;
                    else if (model_keys[mid] < rq.key) lo = mid + 1;
                    else begin
                        r.ok = 1'b1;
                        r.position = mid[POS_W-1:0];
                        r.match_payload = model_pays[mid];
                        break;
                    end
                end
            end
        endcase
        r.table_count = model_count[TCNT_W-1:0];
        return r;
    endfunction

    function automatic t_request make_req(t_func f, logic [KEY_W-1:0] k,
                                          logic [PAY_W-1:0] p,
                                          logic [IDX_W-1:0] fi,
                                          logic [IDX_W-1:0] li);
        t_request rq;
        rq.func = f; rq.key = k; rq.payload = p;
        rq.first_index = fi; rq.last_index = li;
        return rq;
    endfunction

    // Random item; mostly inserts and searches for keys already held.
    function automatic t_request random_req();
        t_request rq;
        int sel;
        sel = $urandom_range(0, 99);
        rq.payload = $urandom;
        rq.first_index = IDX_W'($urandom);
        rq.last_index = IDX_W'($urandom);
        rq.key = ($urandom_range(0, 1) != 0) ? 32'($urandom_range(0, 40)) : $urandom;
        if (sel < 45) begin
            rq.func = FUNC_INSERT;
        end else if (sel < 70) begin
            rq.func = FUNC_SEARCH;
            if (model_count > 0 && sel < 62)
                rq.key = model_keys[$urandom_range(0, model_count - 1)];
        end else if (sel < 85) begin
            rq.func = FUNC_DELETE;
            if (model_count > 0 && sel < 82)
                rq.first_index = IDX_W'($urandom_range(0, model_count - 1));
        end else begin
            rq.func = FUNC_DEL_RANGE;
            if (model_count > 0 && sel < 96) begin
                rq.first_index = IDX_W'($urandom_range(0, model_count - 1));
                rq.last_index = IDX_W'($urandom_range(rq.first_index,
                    (rq.first_index + 6 < model_count) ? rq.first_index + 6
                                                       : model_count - 1));
            end
        end
        return rq;
    endfunction

    // Offer one item, hold until accepted; the expectation is queued on accept.
    task automatic send_item(t_request rq, bit typed, t_result typed_res);
        t_result predicted;
        req_if.valid <= 1'b1;
        req_if.data  <= rq;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        predicted = apply_request(rq);
        if (typed && predicted !== typed_res) begin
            $display("%0t directed row expected %p got %p", $time, typed_res, predicted);
            err_count++;
        end
        result_queue.push_back(predicted);
        sent_items++;
    endtask

    task automatic idle_gap(int n);
        req_if.valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic drain_results();
        req_if.valid <= 1'b0;
        while (result_queue.size() != 0) @(posedge i_clk);
    endtask

    typedef struct {
        t_request rq;
        bit       typed;
        t_result  res;
    } t_row;

    t_row directed_rows [DIRECTED_ROWS];

    initial begin
        // directed table; typed results where they are obvious
        directed_rows[0]  = '{make_req(FUNC_SEARCH, 32'h0, 32'h0, 8'h0, 8'h0), 1, '{0, 0, 0, 0}};
        directed_rows[1]  = '{make_req(FUNC_DELETE, 32'h0, 32'h0, 8'h0, 8'h0), 1, '{0, 0, 0, 0}};
        directed_rows[2]  = '{make_req(FUNC_DEL_RANGE, 32'h0, 32'h0, 8'h0, 8'h0), 1, '{0, 0, 0, 0}};
        directed_rows[3]  = '{make_req(FUNC_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 8'hFF), 1, '{1, 0, 0, 1}};
        directed_rows[4]  = '{make_req(FUNC_INSERT, 32'h0, 32'h0, 8'h0, 8'h0), 1, '{1, 0, 0, 2}};
        directed_rows[5]  = '{make_req(FUNC_INSERT, 32'h5, 32'hA5A5_A5A5, 8'h0, 8'h0), 0, '{0, 0, 0, 0}};
        directed_rows[6]  = '{make_req(FUNC_INSERT, 32'h5, 32'h5A5A_5A5A, 8'h0, 8'h0), 0, '{0, 0, 0, 0}};
        directed_rows[7]  = '{make_req(FUNC_SEARCH, 32'hFFFF_FFFF, 32'h0, 8'h0, 8'h0), 1, '{1, 3, 32'hFFFF_FFFF, 4}};
        directed_rows[8]  = '{make_req(FUNC_SEARCH, 32'h5, 32'h0, 8'h0, 8'h0), 0, '{0, 0, 0, 0}};
        directed_rows[9]  = '{make_req(FUNC_SEARCH, 32'h7, 32'h0, 8'h0, 8'h0), 1, '{0, 0, 0, 4}};
        directed_rows[10] = '{make_req(FUNC_DELETE, 32'h0, 32'h0, 8'hFF, 8'h0), 1, '{0, 0, 0, 4}};
        directed_rows[11] = '{make_req(FUNC_DELETE, 32'h0, 32'h0, 8'h4, 8'h0), 1, '{0, 0, 0, 4}};
        directed_rows[12] = '{make_req(FUNC_DEL_RANGE, 32'h0, 32'h0, 8'h2, 8'h1), 1, '{0, 0, 0, 4}};
        directed_rows[13] = '{make_req(FUNC_DEL_RANGE, 32'h0, 32'h0, 8'h0, 8'hFF), 1, '{0, 0, 0, 4}};
        directed_rows[14] = '{make_req(FUNC_DELETE, 32'h0, 32'h0, 8'h1, 8'h0), 1, '{1, 0, 0, 3}};
        directed_rows[15] = '{make_req(FUNC_INSERT, 32'h8000_0000, 32'h1234_5678, 8'h0, 8'h0), 0, '{0, 0, 0, 0}};
        directed_rows[16] = '{make_req(FUNC_DEL_RANGE, 32'h0, 32'h0, 8'h1, 8'h2), 1, '{1, 0, 0, 2}};
        directed_rows[17] = '{make_req(FUNC_DEL_RANGE, 32'h0, 32'h0, 8'h0, 8'h1), 1, '{1, 0, 0, 0}};
        directed_rows[18] = '{make_req(FUNC_INSERT, 32'h1, 32'h1, 8'h0, 8'h0), 1, '{1, 0, 0, 1}};
        directed_rows[19] = '{make_req(FUNC_DELETE, 32'h0, 32'h0, 8'h0, 8'h0), 1, '{1, 0, 0, 0}};

        err_count = 0;
        sent_items = 0;
        model_count = 0;
        i_rst_n = 1'b0;
        req_if.valid = 1'b0;
        req_if.data = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            send_item(directed_rows[i].rq, directed_rows[i].typed, directed_rows[i].res);
            if ($urandom_range(0, 2) == 0) idle_gap($urandom_range(1, 3));
        end
        drain_results();

        // fill the table to capacity, then hit the full case
        for (int i = 0; i < ENTRIES + 3; i++) begin
            send_item(make_req(FUNC_INSERT, $urandom_range(0, 300), $urandom,
                               8'd0, 8'd0), 0, '0);
        end
        // sender pause until all results are back
        drain_results();
        send_item(make_req(FUNC_SEARCH, model_keys[ENTRIES-1], 32'd0, 8'd0, 8'd0), 0, '0);
        send_item(make_req(FUNC_DEL_RANGE, 32'd0, 32'd0, 8'd0, 8'd255), 0, '0);

        // random part in bursts
        while (sent_items < DIRECTED_ROWS + ENTRIES + 5 + RANDOM_ITEMS) begin
            repeat ($urandom_range(1, 24)) send_item(random_req(), 0, '0);
            if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 12));
        end
        drain_results();
        repeat (600) @(posedge i_clk);
        if (err_count == 0) begin
            $display("sorted_key_table: match");
        end else begin
            $display("sorted_key_table: mismatch");
        end
        $finish;
    end

    // one long receiver stall early in the random part
    initial begin
        hold_off = 1'b0;
        wait (sent_items >= DIRECTED_ROWS + ENTRIES + 40);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (3000) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    // receiver: stall pattern with quiet stretches
    initial begin
        int phase;
        phase = 0;
        res_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            phase++;
            if (hold_off) res_if.ready <= 1'b0;
            else if ((phase / 200) % 2 == 0) res_if.ready <= 1'b1;
            else res_if.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (result_queue.size() == 0) begin
                $display("%0t unexpected result %p", $time, res_if.data);
                err_count++;
            end else begin
                want = result_queue.pop_front();
                if (res_if.data.ok !== want.ok) begin
                    $display("%0t ok expected %0d got %0d", $time, want.ok, res_if.data.ok);
                    err_count++;
                end
                if (res_if.data.position !== want.position) begin
                    $display("%0t position expected %0d got %0d", $time,
                             want.position, res_if.data.position);
                    err_count++;
                end
                if (res_if.data.match_payload !== want.match_payload) begin
                    $display("%0t match_payload expected %h got %h", $time,
                             want.match_payload, res_if.data.match_payload);
                    err_count++;
                end
                if (res_if.data.table_count !== want.table_count) begin
                    $display("%0t table_count expected %0d got %0d", $time,
                             want.table_count, res_if.data.table_count);
                    err_count++;
                end
            end
        end
    end

    // run limit
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT) begin
                $display("sorted_key_table: mismatch");
                $finish;
            end
        end
    end

endmodule
